// ===== rtl/core/mrpt_pkg.sv =====
// Package for the Miller-Rabin primality tester.
// Holds the sequencer state type and the two witness bases; no dependencies.
`default_nettype none

package mrpt_pkg;

    localparam logic [1:0] BASE_LO = 2'd2;
    localparam logic [1:0] BASE_HI = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_SETUP,
        ST_BASE,
        ST_EXP,
        ST_EXP_ACC,
        ST_EXP_SQR,
        ST_CHECK,
        ST_SQ,
        ST_SQ_WAIT,
        ST_PASS,
        ST_RESULT
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/core/mrpt_modmul.sv =====
// Shift-add modular multiplier: product = x * y mod n, one bit of y per cycle.
// Operands must be below n. Standalone; used by the primality tester top level.
`default_nettype none

module mrpt_modmul #(
    parameter int WIDTH = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [WIDTH-1:0] i_x,
    input  wire logic [WIDTH-1:0] i_y,
    input  wire logic [WIDTH-1:0] i_n,
    output logic                  o_done,
    output logic [WIDTH-1:0]      o_product
);

    localparam int CW = $clog2(WIDTH);

    logic [WIDTH-1:0] r_x, r_y, r_n, r_acc;
    logic [CW-1:0]    r_cnt;
    logic             r_busy, r_done;

    logic [WIDTH:0]   dbl, dbl_red, sum, sum_red;

    // acc = (2*acc + bit*x) mod n, both terms kept below 2n
    always_comb begin
        dbl     = {r_acc, 1'b0};
        dbl_red = (dbl >= {1'b0, r_n}) ? dbl - {1'b0, r_n} : dbl;
        sum     = dbl_red + (r_y[r_cnt] ? {1'b0, r_x} : '0);
        sum_red = (sum >= {1'b0, r_n}) ? sum - {1'b0, r_n} : sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_y   <= i_y;
            r_n   <= i_n;
            r_acc <= '0;
            r_cnt <= CW'(WIDTH - 1);
        end else if (r_busy) begin
            r_acc <= sum_red[WIDTH-1:0];
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

`default_nettype wire

// ===== rtl/core/miller_rabin_primality_test_top.sv =====
// Miller-Rabin strong probable-prime test to bases 2 and 3, top level.
// Depends on mrpt_pkg and mrpt_modmul.
//
// Usage:
//   Input stream s_axis: one candidate per request, low NUM_WIDTH bits used.
//   Output stream m_axis: one verdict per candidate, bit 0 = is_prime.
//   s_axis_tready is high only while the sequencer is idle; one candidate is
//   worked on at a time.
// Sequence:
//   Values below 2 and even values go from ST_CLASSIFY straight to ST_RESULT.
//   Odd values: ST_SETUP shifts n-1 down to split it into 2^s*d, then per base
//   about (bits(d) - 1 + ones(d) + s) modular multiplies follow, each an issue
//   plus the shift-add multiplier. The next candidate is accepted only after
//   the current verdict has left the sequencer.
// Reset (synchronous, active low) returns the sequencer to idle and drops any
// pending verdict.
// Stall: the verdict sits in an output register; a new candidate is taken
// while it waits, and a finished verdict holds in the sequencer until the
// output register is free.

`default_nettype none

module miller_rabin_primality_test_top #(
    parameter int NUM_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] candidate
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata    // [0] is_prime, [7:1] zero
);

    import mrpt_pkg::*;

    localparam int SW = $clog2(NUM_WIDTH);

    t_state r_state, n_state;

    logic [NUM_WIDTH-1:0] r_n, r_nm1, r_d, r_e, r_acc, r_b;
    logic [SW-1:0]        r_s, r_k;
    logic                 r_base_hi;
    logic                 r_verdict;
    logic                 r_out_valid, r_out_data;

    logic                 mul_start, mul_done;
    logic [NUM_WIDTH-1:0] mul_x, mul_y, mul_p;
    logic [NUM_WIDTH-1:0] base;
    logic                 out_free;

    assign base     = r_base_hi ? NUM_WIDTH'(BASE_HI) : NUM_WIDTH'(BASE_LO);
    assign out_free = !r_out_valid || m_axis_tready;

    mrpt_modmul #(
        .WIDTH (NUM_WIDTH)
    ) u_modmul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_x       (mul_x),
        .i_y       (mul_y),
        .i_n       (r_n),
        .o_done    (mul_done),
        .o_product (mul_p)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) n_state = ST_CLASSIFY;
            end
            ST_CLASSIFY: begin
                if (r_n < NUM_WIDTH'(2) || !r_n[0]) n_state = ST_RESULT;
                else                                n_state = ST_SETUP;
            end
            ST_SETUP: begin
                if (r_d[0]) n_state = ST_BASE;
            end
            ST_BASE: begin
                if (r_n == base) n_state = ST_PASS;
                else             n_state = ST_EXP;
            end
            ST_EXP: begin
                if (r_e == '0)  n_state = ST_CHECK;
                else if (r_e[0]) n_state = ST_EXP_ACC;
                else             n_state = ST_EXP_SQR;
            end
            ST_EXP_ACC: begin
                if (mul_done) n_state = ST_EXP;
            end
            ST_EXP_SQR: begin
                if (mul_done) n_state = ST_EXP;
            end
            ST_CHECK: begin
                if (r_acc == NUM_WIDTH'(1)) n_state = ST_PASS;
                else                        n_state = ST_SQ;
            end
            ST_SQ: begin
                if (r_k == r_s)          n_state = ST_RESULT;
                else if (r_acc == r_nm1) n_state = ST_PASS;
                else                     n_state = ST_SQ_WAIT;
            end
            ST_SQ_WAIT: begin
                if (mul_done) n_state = ST_SQ;
            end
            ST_PASS: begin
                if (r_base_hi) n_state = ST_RESULT;
                else           n_state = ST_BASE;
            end
            ST_RESULT: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_axis_tready = 1'b0;
        mul_start     = 1'b0;
        mul_x         = r_acc;
        mul_y         = r_b;
        unique case (r_state)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_EXP: begin
                mul_start = (r_e != '0);
                mul_x     = r_e[0] ? r_acc : r_b;
                mul_y     = r_b;
            end
            ST_SQ: begin
                mul_start = (r_k != r_s) && (r_acc != r_nm1);
                mul_x     = r_acc;
                mul_y     = r_acc;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_RESULT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_n <= s_axis_tdata[NUM_WIDTH-1:0];
            end
            ST_CLASSIFY: begin
                r_nm1     <= r_n - 1'b1;
                r_d       <= r_n - 1'b1;
                r_s       <= '0;
                r_base_hi <= 1'b0;
                // small and even values settle here
                r_verdict <= (r_n == NUM_WIDTH'(2));
            end
            ST_SETUP: begin
                if (!r_d[0]) begin
                    r_d <= r_d >> 1;
                    r_s <= r_s + 1'b1;
                end
            end
            ST_BASE: begin
                r_acc <= NUM_WIDTH'(1);
                r_b   <= base;
                r_e   <= r_d;
                r_k   <= '0;
            end
            ST_EXP_ACC: begin
                if (mul_done) begin
                    r_acc  <= mul_p;
                    r_e[0] <= 1'b0;
                end
            end
            ST_EXP_SQR: begin
                if (mul_done) begin
                    r_b <= mul_p;
                    r_e <= r_e >> 1;
                end
            end
            ST_SQ: begin
                if (r_k == r_s) r_verdict <= 1'b0;
            end
            ST_SQ_WAIT: begin
                if (mul_done) begin
                    r_acc <= mul_p;
                    r_k   <= r_k + 1'b1;
                end
            end
            ST_PASS: begin
                if (r_base_hi) r_verdict <= 1'b1;
                r_base_hi <= 1'b1;
            end
            ST_RESULT: begin
                if (out_free) r_out_data <= r_verdict;
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_data};

endmodule

`default_nettype wire

// ===== tb/tb_miller_rabin_primality_test_top.sv =====
// Testbench for miller_rabin_primality_test_top: streams candidates and checks each verdict
// against a strong-probable-prime predictor to bases 2 and 3 built at 64-bit width.
// Depends only on the RTL top level (and the package and multiplier it pulls in).
`default_nettype none

module tb_miller_rabin_primality_test_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          NUM_WIDTH     = 32;
    localparam int          HALF_PERIOD   = 10;
    localparam int          RESET_CYCLES  = 6;
    localparam int          STALL_LIMIT   = 50000;
    localparam int          SETTLE_CYCLES = 5000;
    localparam int          BATCH_ITEMS   = 28;
    localparam logic [63:0] WITNESS_A     = 64'd2;
    localparam logic [63:0] WITNESS_B     = 64'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;    // [31:0] candidate
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;    // [0] is_prime, [7:1] zero

    logic        verdict_q[$];
    logic        expected_verdict;
    int          error_count;
    int          candidates_sent;
    int          verdicts_checked;
    int          primes_reported;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          quiet_cycles;

    miller_rabin_primality_test_top #(
        .NUM_WIDTH(NUM_WIDTH)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // ---------------- verdict predictor ----------------

    function automatic logic [63:0] mul_mod(input logic [63:0] x, input logic [63:0] y,
                                            input logic [63:0] n);
        return (x * y) % n;
    endfunction

    function automatic bit witness_passes(input logic [63:0] n, input logic [63:0] d,
                                          input int unsigned s, input logic [63:0] a);
        logic [63:0] acc;
        logic [63:0] pow;
        logic [63:0] e;
        int unsigned k;
        if (n == a) return 1'b1;
        acc = 64'd1;
        pow = a % n;
        e   = d;
        while (e != 64'd0) begin
            if (e[0]) acc = mul_mod(acc, pow, n);
            pow = mul_mod(pow, pow, n);
            e   = e >> 1;
        end
        if (acc == 64'd1) return 1'b1;
        for (k = 0; k < s; k++) begin
            if (acc == n - 64'd1) return 1'b1;
            acc = mul_mod(acc, acc, n);
        end
        return 1'b0;
    endfunction

    function automatic logic predict_is_prime(input logic [31:0] cand);
        logic [63:0] n;
        logic [63:0] d;
        int unsigned s;
        n = {32'd0, cand} & ((64'd1 << NUM_WIDTH) - 64'd1);
        if (n < 64'd2) return 1'b0;
        if (!n[0]) return (n == 64'd2);
        d = n - 64'd1;
        s = 0;
        while (!d[0]) begin
            d = d >> 1;
            s++;
        end
        return witness_passes(n, d, s, WITNESS_A) && witness_passes(n, d, s, WITNESS_B);
    endfunction

    // ---------------- driving ----------------

    task automatic queue_verdict(input logic verdict);
        verdict_q = {verdict_q, verdict};
    endtask

    task automatic send_candidate(input logic [31:0] cand);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= cand;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        queue_verdict(predict_is_prime(cand));
        candidates_sent++;
    endtask

    task automatic wait_for_verdicts();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (verdict_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_random_batch(input int count);
        logic [31:0] cand;
        int          shift;
        repeat (count) begin
            case ($urandom_range(9))
                0, 1: cand = $urandom_range(255);
                2, 3: cand = $urandom_range(32'h000F_FFFF) | 32'd1;
                4: begin
                    // long run of trailing zeros in n-1: many squarings after the power
                    shift = $urandom_range(31, 1);
                    cand  = ($urandom << shift) | 32'd1;
                end
                5:       cand = $urandom & ~32'd1;
                default: cand = $urandom | 32'd1;
            endcase
            send_candidate(cand);
        end
    endtask

    // ---------------- tests ----------------

    task automatic test_directed_corners();
        logic [31:0] corners[$];
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        corners = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd25, 32'd97,
                    32'd561, 32'd2047, 32'd65537, 32'd1373653, 32'd25326001,
                    32'd3215031751, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                    32'hC000_0001, 32'hAAAA_AAAB, 32'h5555_5555, 32'hFFFF_FFFB,
                    32'hFFFF_FFFE, 32'hFFFF_FFFF};
        foreach (corners[i]) send_candidate(corners[i]);
    endtask

    task automatic test_random_no_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_random_batch(BATCH_ITEMS);
    endtask

    task automatic test_random_sender_idle();
        send_idle_pct  = 62;
        recv_stall_pct = 0;
        send_random_batch(BATCH_ITEMS);
    endtask

    task automatic test_random_receiver_stall();
        send_idle_pct  = 0;
        recv_stall_pct = 62;
        send_random_batch(BATCH_ITEMS);
    endtask

    task automatic test_random_both_idle();
        send_idle_pct  = 24;
        recv_stall_pct = 24;
        send_random_batch(BATCH_ITEMS);
    endtask

    task automatic test_drain_pause();
        send_idle_pct  = 0;
        recv_stall_pct = 24;
        send_random_batch(4);
        // hold the input until every pending verdict has been delivered
        wait_for_verdicts();
        send_random_batch(4);
    endtask

    // ---------------- checking ----------------

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic exp);
        $display("%0t ERROR %s: got 0x%02h expected is_prime=%0d", $time, what, got, exp);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (verdict_q.size() == 0) begin
                report_mismatch("verdict with no request pending", m_axis_tdata, 1'b0);
            end else begin
                expected_verdict = verdict_q.pop_front();
                verdicts_checked++;
                if (m_axis_tdata[0]) primes_reported++;
                if (m_axis_tdata[0] !== expected_verdict)
                    report_mismatch("is_prime", m_axis_tdata, expected_verdict);
                if (m_axis_tdata[7:1] !== 7'd0)
                    report_mismatch("nonzero padding", m_axis_tdata, expected_verdict);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t watchdog: no request moved for %0d cycles, %0d verdicts pending",
                     $time, quiet_cycles, verdict_q.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        s_axis_tvalid    = 1'b0;
        s_axis_tdata     = 32'd0;
        m_axis_tready    = 1'b0;
        error_count      = 0;
        candidates_sent  = 0;
        verdicts_checked = 0;
        primes_reported  = 0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        quiet_cycles     = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_corners();
        test_random_no_idle();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_drain_pause();
        test_random_both_idle();

        wait_for_verdicts();
        // catch any stray verdict the sequencer might still emit
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d candidates, checked %0d verdicts (%0d prime): corner values,",
                 candidates_sent, verdicts_checked, primes_reported);
        $display("random widths and long 2^s splits under gaps, stalls and a full drain.");
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/mrpt_pkg.sv
rtl/core/mrpt_modmul.sv
rtl/core/miller_rabin_primality_test_top.sv
tb/tb_miller_rabin_primality_test_top.sv
